[rtl/assert_macros.svh]
// assertion macros for the solver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dls_pkg.sv]
// shared types and constants for the damped least-squares solver
package dls_pkg;

    localparam int JAC_W       = 16;
    localparam int DAMP_W      = 16;
    localparam int RATE_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int BV_W        = 2 * JAC_W + 2;
    localparam int MUL_CHUNK_W = 18;
    localparam int MUL_LAT     = 2;
    localparam int DIV_QB      = RATE_W + 1;
    localparam int DIV_LAT     = DIV_QB + 3;

    localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd41;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SINGULAR  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

endpackage

[rtl/damped_least_squares_3x3_solve.sv]
// damped least-squares 3x3 solver top level
// stages: a_reg, multipliers, cof_reg, multipliers, det_reg and acc_reg, divider, rate_reg
// throughput: one beat per cycle; the whole pipeline advances while the output is free or taken
// the divider resolves one quotient bit per stage, 33 stages per joint rate
// reset: synchronous active-low aresetn clears valid bits and sets damping to 41
`include "assert_macros.svh"

module damped_least_squares_3x3_solve import dls_pkg::*; #(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DAMP_W-1:0]        cfg_damping,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [JAC_W-1:0]  s_jac_00,
    input  logic signed [JAC_W-1:0]  s_jac_01,
    input  logic signed [JAC_W-1:0]  s_jac_02,
    input  logic signed [JAC_W-1:0]  s_jac_10,
    input  logic signed [JAC_W-1:0]  s_jac_11,
    input  logic signed [JAC_W-1:0]  s_jac_12,
    input  logic signed [JAC_W-1:0]  s_jac_20,
    input  logic signed [JAC_W-1:0]  s_jac_21,
    input  logic signed [JAC_W-1:0]  s_jac_22,
    input  logic signed [JAC_W-1:0]  s_vel_x,
    input  logic signed [JAC_W-1:0]  s_vel_y,
    input  logic signed [JAC_W-1:0]  s_vel_z,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [RATE_W-1:0] m_rate_hip,
    output logic signed [RATE_W-1:0] m_rate_thigh,
    output logic signed [RATE_W-1:0] m_rate_knee,
    output logic [STATUS_W-1:0]      m_status
);

    localparam int AW    = ((JAC_W + IN_FRAC_BITS > 2 * JAC_W) ?
                            JAC_W + IN_FRAC_BITS : 2 * JAC_W) + 2;
    localparam int CF_W  = 2 * AW + 1;
    localparam int DET_W = AW + CF_W + 2;
    localparam int NUM_W = CF_W + BV_W + 2;
    localparam int LAT   = 4 + 2 * MUL_LAT + DIV_LAT;
    localparam int DLY   = MUL_LAT + 1;

    logic en;

    logic [DAMP_W-1:0] damping_reg;
    logic [LAT-1:0]    vld_reg;

    logic signed [JAC_W-1:0] jx [3][3];
    logic signed [JAC_W-1:0] vx [3];

    logic signed [AW-1:0]   a_next  [3][3];
    logic signed [AW-1:0]   a_reg   [3][3];
    logic signed [BV_W-1:0] bv_next [3];
    logic signed [BV_W-1:0] bv_reg  [3];

    logic signed [AW-1:0]   a0_dly_reg [DLY][3];
    logic signed [BV_W-1:0] bv_dly_reg [DLY][3];

    logic signed [2*AW-1:0]      cp_p [3][3];
    logic signed [2*AW-1:0]      cq_p [3][3];
    logic signed [CF_W-1:0]      cof_reg [3][3];
    logic signed [CF_W+AW-1:0]   dm_p [3];
    logic signed [CF_W+BV_W-1:0] am_p [3][3];

    logic signed [DET_W-1:0] det_reg;
    logic signed [NUM_W-1:0] acc_reg [3];
    logic signed [DET_W-1:0] det_next;
    logic signed [NUM_W-1:0] acc_next [3];

    logic signed [RATE_W-1:0] div_rate [3];
    logic                     div_sat  [3];
    logic [DIV_LAT-1:0]       sing_dly_reg;

    logic signed [RATE_W-1:0] rate_reg [3];
    status_t                  status_reg;

    assign en        = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_comb begin
        jx[0][0] = s_jac_00; jx[0][1] = s_jac_01; jx[0][2] = s_jac_02;
        jx[1][0] = s_jac_10; jx[1][1] = s_jac_11; jx[1][2] = s_jac_12;
        jx[2][0] = s_jac_20; jx[2][1] = s_jac_21; jx[2][2] = s_jac_22;
        vx[0] = s_vel_x; vx[1] = s_vel_y; vx[2] = s_vel_z;
    end

    // normal matrix with damping on the diagonal, and right-hand side
    always_comb begin
        logic signed [2*JAC_W-1:0] pr;
        for (int i = 0; i < 3; i++) begin
            bv_next[i] = '0;
            for (int k = 0; k < 3; k++) begin
                a_next[i][k] = '0;
                for (int j = 0; j < 3; j++) begin
                    pr           = jx[j][i] * jx[j][k];
                    a_next[i][k] = a_next[i][k] + AW'(pr);
                end
                if (i == k) begin
                    a_next[i][k] = a_next[i][k] + (AW'({1'b0, damping_reg}) <<< IN_FRAC_BITS);
                end
            end
            for (int j = 0; j < 3; j++) begin
                pr         = jx[j][i] * vx[j];
                bv_next[i] = bv_next[i] + BV_W'(pr);
            end
        end
    end

    // cofactor products
    for (genvar gi = 0; gi < 3; gi++) begin : g_cof_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_cof_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;

            dls_mul #(.AW(AW), .BW(AW)) u_cp (
                .aclk (aclk),
                .en   (en),
                .a    (a_reg[I1][J1]),
                .b    (a_reg[I2][J2]),
                .p    (cp_p[gi][gj])
            );

            dls_mul #(.AW(AW), .BW(AW)) u_cq (
                .aclk (aclk),
                .en   (en),
                .a    (a_reg[I1][J2]),
                .b    (a_reg[I2][J1]),
                .p    (cq_p[gi][gj])
            );
        end
    end

    // determinant terms and adjugate times right-hand side
    for (genvar gj = 0; gj < 3; gj++) begin : g_det
        dls_mul #(.AW(CF_W), .BW(AW)) u_dm (
            .aclk (aclk),
            .en   (en),
            .a    (cof_reg[0][gj]),
            .b    (a0_dly_reg[DLY-1][gj]),
            .p    (dm_p[gj])
        );
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_acc_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_acc_col
            dls_mul #(.AW(CF_W), .BW(BV_W)) u_am (
                .aclk (aclk),
                .en   (en),
                .a    (cof_reg[gj][gi]),
                .b    (bv_dly_reg[DLY-1][gj]),
                .p    (am_p[gi][gj])
            );
        end
    end

    always_comb begin
        det_next = '0;
        for (int j = 0; j < 3; j++) begin
            det_next = det_next + DET_W'(dm_p[j]);
        end
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = '0;
            for (int j = 0; j < 3; j++) begin
                acc_next[i] = acc_next[i] + NUM_W'(am_p[i][j]);
            end
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_div
        dls_div #(.NW(NUM_W), .DW(DET_W), .OFB(OUT_FRAC_BITS)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (acc_reg[gi]),
            .den  (det_reg),
            .rate (div_rate[gi]),
            .sat  (div_sat[gi])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_reg <= DAMPING_RESET;
            vld_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                damping_reg <= cfg_damping;
            end
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= a_next;
            bv_reg <= bv_next;

            a0_dly_reg[0] <= a_reg[0];
            bv_dly_reg[0] <= bv_reg;
            for (int d = 1; d < DLY; d++) begin
                a0_dly_reg[d] <= a0_dly_reg[d-1];
                bv_dly_reg[d] <= bv_dly_reg[d-1];
            end

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cof_reg[i][j] <= CF_W'(cp_p[i][j]) - CF_W'(cq_p[i][j]);
                end
            end

            det_reg <= det_next;
            acc_reg <= acc_next;

            sing_dly_reg <= {sing_dly_reg[DIV_LAT-2:0], (det_reg == '0)};

            for (int i = 0; i < 3; i++) begin
                rate_reg[i] <= sing_dly_reg[DIV_LAT-1] ? '0 : div_rate[i];
            end
            if (sing_dly_reg[DIV_LAT-1]) begin
                status_reg <= ST_SINGULAR;
            end else if (div_sat[0] || div_sat[1] || div_sat[2]) begin
                status_reg <= ST_SATURATED;
            end else begin
                status_reg <= ST_OK;
            end
        end
    end

    assign m_valid      = vld_reg[LAT-1];
    assign m_rate_hip   = rate_reg[0];
    assign m_rate_thigh = rate_reg[1];
    assign m_rate_knee  = rate_reg[2];
    assign m_status     = status_reg;

    `DLS_ASSERT_NOW(a_singular_zero, aclk, aresetn,
        m_valid && (m_status == ST_SINGULAR),
        (m_rate_hip == '0) && (m_rate_thigh == '0) && (m_rate_knee == '0),
        "singular result carries a nonzero rate")

    `DLS_ASSERT_NOW(a_sat_at_bound, aclk, aresetn,
        m_valid && (m_status == ST_SATURATED),
        (m_rate_hip == 32'sh7fffffff) || (m_rate_hip == 32'sh80000000) ||
        (m_rate_thigh == 32'sh7fffffff) || (m_rate_thigh == 32'sh80000000) ||
        (m_rate_knee == 32'sh7fffffff) || (m_rate_knee == 32'sh80000000),
        "saturated status without a rate at its bound")

    `DLS_ASSERT_NEXT(a_stall_holds, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_rate_hip) && $stable(m_status),
        "stalled result beat changed")

endmodule

[rtl/dls_mul.sv]
// pipelined signed multiplier, operand b split into chunks, two register stages
module dls_mul import dls_pkg::*; #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int CHW = MUL_CHUNK_W;
    localparam int NC  = (BW + CHW - 1) / CHW;
    localparam int EW  = NC * CHW;
    localparam int PPW = AW + CHW + 1;
    localparam int SW  = AW + EW + 1;

    logic signed [EW-1:0]    bx;
    logic signed [PPW-1:0]   pp_next [NC];
    logic signed [PPW-1:0]   pp_reg  [NC];
    logic signed [AW+BW-1:0] p_next;
    logic signed [AW+BW-1:0] p_reg;

    assign bx = EW'(b);

    always_comb begin
        logic signed [CHW:0] ck;
        for (int k = 0; k < NC; k++) begin
            if (k == NC - 1) begin
                ck = $signed({bx[k*CHW+CHW-1], bx[k*CHW +: CHW]});
            end else begin
                ck = $signed({1'b0, bx[k*CHW +: CHW]});
            end
            pp_next[k] = a * ck;
        end
    end

    always_comb begin
        logic signed [SW-1:0] s;
        s = '0;
        for (int k = 0; k < NC; k++) begin
            s = s + (SW'(pp_reg[k]) <<< (k * CHW));
        end
        p_next = $signed(s[AW+BW-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg <= pp_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/dls_div.sv]
// pipelined restoring divider, one quotient bit a stage, rounded and saturated
module dls_div import dls_pkg::*; #(
    parameter int NW  = 104,
    parameter int DW  = 104,
    parameter int OFB = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [NW-1:0]     num,
    input  logic signed [DW-1:0]     den,
    output logic signed [RATE_W-1:0] rate,
    output logic                     sat
);

    localparam int QB = DIV_QB;
    localparam int RW = NW + OFB + 1;
    localparam int CW = ((RW > DW + QB) ? RW : DW + QB) + 1;

    logic [NW-1:0] nmag;
    logic [DW-1:0] dmag;

    logic [RW-1:0] ra_reg;
    logic [DW-1:0] da_reg;
    logic          nega_reg;

    logic [RW-1:0] r_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic [QB-1:0] t_reg   [QB+1];

    logic [RW-1:0] r_next [QB];
    logic [QB-1:0] t_next [QB];

    logic [QB-1:0]     qr;
    logic [QB-1:0]     lim;
    logic [QB-1:0]     mag;
    logic              sat_next;
    logic              negf;
    logic [RATE_W-1:0] rate_next;
    logic [RATE_W-1:0] rate_reg;
    logic              sat_reg;

    assign nmag = num[NW-1] ? NW'(~num + 1'b1) : NW'(num);
    assign dmag = den[DW-1] ? DW'(~den + 1'b1) : DW'(den);

    always_comb begin
        logic [CW-1:0] dsh;
        logic          ge;
        for (int s = 0; s < QB; s++) begin
            dsh       = CW'(d_reg[s]) << (QB - 1 - s);
            ge        = CW'(r_reg[s]) >= dsh;
            r_next[s] = ge ? RW'(CW'(r_reg[s]) - dsh) : r_reg[s];
            t_next[s] = t_reg[s] | (QB'(ge) << (QB - 1 - s));
        end
    end

    assign qr       = QB'((({1'b0, t_reg[QB]}) + 1'b1) >> 1);
    assign lim      = neg_reg[QB] ? (QB'(1) << (RATE_W - 1)) : ((QB'(1) << (RATE_W - 1)) - 1'b1);
    assign sat_next = ovf_reg[QB] || (qr > lim);
    assign mag      = sat_next ? lim : qr;
    assign negf     = neg_reg[QB] && (ovf_reg[QB] || (qr != '0));
    assign rate_next = negf ? RATE_W'(~mag + 1'b1) : RATE_W'(mag);

    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg   <= RW'(nmag) << (OFB + 1);
            da_reg   <= dmag;
            nega_reg <= num[NW-1] ^ den[DW-1];

            r_reg[0]   <= ra_reg;
            d_reg[0]   <= da_reg;
            neg_reg[0] <= nega_reg;
            ovf_reg[0] <= CW'(ra_reg) >= (CW'(da_reg) << QB);
            t_reg[0]   <= '0;

            for (int s = 0; s < QB; s++) begin
                r_reg[s+1]   <= r_next[s];
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                t_reg[s+1]   <= t_next[s];
            end

            rate_reg <= rate_next;
            sat_reg  <= sat_next;
        end
    end

    assign rate = $signed(rate_reg);
    assign sat  = sat_reg;

endmodule

[sim/tb_top.sv]
// self-checking testbench for the damped least-squares 3x3 solver
`timescale 1ns / 100ps

import dls_pkg::*;

typedef struct {
    logic signed [JAC_W-1:0] jac [9];
    logic signed [JAC_W-1:0] vel [3];
} leg_beat_t;

typedef struct {
    logic signed [RATE_W-1:0] rate [3];
    status_t                  status;
} joint_rates_t;

class rate_scoreboard;
    joint_rates_t     rates_due [$];
    logic [DAMP_W-1:0] damping = DAMPING_RESET;
    int               errors = 0;
    int               checked = 0;
    int               n_singular = 0;
    int               n_saturated = 0;

    function automatic joint_rates_t solve_leg(leg_beat_t it);
        logic signed [191:0] jm [3][3];
        logic signed [191:0] am [3][3];
        logic signed [191:0] bv [3];
        logic signed [191:0] cof [3][3];
        logic signed [191:0] det, acc;
        logic [191:0] nm, dm, q, r;
        logic [63:0] lim;
        logic neg, sat;
        joint_rates_t res;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) jm[i][j] = it.jac[i*3+j];
        end
        for (int i = 0; i < 3; i++) begin
            bv[i] = 0;
            for (int k = 0; k < 3; k++) begin
                am[i][k] = 0;
                for (int j = 0; j < 3; j++) am[i][k] += jm[j][i] * jm[j][k];
            end
            am[i][i] += $signed({176'd0, damping}) <<< 12;
            for (int j = 0; j < 3; j++) bv[i] += jm[j][i] * 192'(signed'(it.vel[j]));
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cof[i][j] = am[(i+1)%3][(j+1)%3] * am[(i+2)%3][(j+2)%3]
                          - am[(i+1)%3][(j+2)%3] * am[(i+2)%3][(j+1)%3];
            end
        end
        det = 0;
        for (int j = 0; j < 3; j++) det += am[0][j] * cof[0][j];
        if (det == 0) begin
            foreach (res.rate[i]) res.rate[i] = '0;
            res.status = ST_SINGULAR;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += cof[j][i] * bv[j];
            nm = (acc < 0 ? -acc : acc) << 16;
            dm = det < 0 ? -det : det;
            q = nm / dm;
            r = nm % dm;
            if ((r << 1) >= dm) q = q + 1;
            neg = ((acc < 0) != (det < 0)) && (q != 0);
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (q > lim) begin
                q = lim;
                sat = 1'b1;
            end
            res.rate[i] = neg ? 32'(-q) : 32'(q);
        end
        res.status = sat ? ST_SATURATED : ST_OK;
        return res;
    endfunction

    function void note_item(leg_beat_t it);
        rates_due.push_back(solve_leg(it));
    endfunction

    function void check_result(joint_rates_t got);
        joint_rates_t want;
        if (rates_due.size() == 0) begin
            $display("%0t: unexpected result beat status %0d", $realtime, got.status);
            errors++;
            return;
        end
        want = rates_due.pop_front();
        checked++;
        if (want.status == ST_SINGULAR) n_singular++;
        if (want.status == ST_SATURATED) n_saturated++;
        for (int i = 0; i < 3; i++) begin
            if (got.rate[i] !== want.rate[i]) begin
                $display("%0t: rate %0d expected %0d actual %0d", $realtime, i,
                         want.rate[i], got.rate[i]);
                errors++;
            end
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                     got.status);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [DAMP_W-1:0] cfg_damping = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [JAC_W-1:0] s_jac [9];
    logic signed [JAC_W-1:0] s_vel [3];
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [RATE_W-1:0] m_rate_hip, m_rate_thigh, m_rate_knee;
    logic [STATUS_W-1:0] m_status;

    rate_scoreboard sb = new();
    int sent = 0;
    bit hold_done = 1'b0;

    initial begin
        foreach (s_jac[i]) s_jac[i] = '0;
        foreach (s_vel[i]) s_vel[i] = '0;
    end

    damped_least_squares_3x3_solve dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_damping(cfg_damping),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_jac_00(s_jac[0]), .s_jac_01(s_jac[1]), .s_jac_02(s_jac[2]),
        .s_jac_10(s_jac[3]), .s_jac_11(s_jac[4]), .s_jac_12(s_jac[5]),
        .s_jac_20(s_jac[6]), .s_jac_21(s_jac[7]), .s_jac_22(s_jac[8]),
        .s_vel_x(s_vel[0]), .s_vel_y(s_vel[1]), .s_vel_z(s_vel[2]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rate_hip(m_rate_hip), .m_rate_thigh(m_rate_thigh), .m_rate_knee(m_rate_knee),
        .m_status(m_status)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        joint_rates_t got;
        if (aresetn && m_valid && m_ready) begin
            got.rate[0] = m_rate_hip;
            got.rate[1] = m_rate_thigh;
            got.rate[2] = m_rate_knee;
            got.status = status_t'(m_status);
            sb.check_result(got);
        end
    end

    // receiver: random stalls plus one long hold-off to back the pipeline up
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && sent >= 400) begin
                hold_done = 1'b1;
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
            end
            g = pick_gap();
            if (g > 0) begin
                m_ready = 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_leg(leg_beat_t it);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_jac = it.jac;
        s_vel = it.vel;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        sent++;
        @(negedge aclk);
    endtask

    task automatic write_damping(logic [DAMP_W-1:0] val);
        s_valid = 1'b0;
        while (sb.rates_due.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        cfg_damping = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.damping = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic leg_beat_t make_leg(int mode);
        leg_beat_t it;
        foreach (it.jac[i]) it.jac[i] = 16'($urandom_range(0, 65535));
        foreach (it.vel[i]) it.vel[i] = 16'($urandom_range(0, 65535));
        case (mode)
            1: begin
                foreach (it.jac[i]) it.jac[i] = 16'($urandom_range(0, 8191) - 4096);
            end
            2: begin
                for (int r = 0; r < 3; r++) it.jac[r*3+2] = it.jac[r*3];
            end
            3: begin
                foreach (it.jac[i]) it.jac[i] = 16'($urandom_range(0, 8) - 4);
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic leg_beat_t fill_leg(logic signed [JAC_W-1:0] jv,
                                           logic signed [JAC_W-1:0] vv, bit diag);
        leg_beat_t it;
        foreach (it.jac[i]) it.jac[i] = (diag && (i % 4 != 0)) ? 16'sd0 : jv;
        foreach (it.vel[i]) it.vel[i] = vv;
        return it;
    endfunction

    initial begin
        logic [DAMP_W-1:0] damp_plan [6];
        int p;
        damp_plan = '{16'd0, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd4096};
        damp_plan[3] = 16'($urandom_range(0, 65535));
        damp_plan[4] = 16'($urandom_range(0, 255));
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // extremes at the reset damping
        send_leg(fill_leg(16'sd0, 16'sd0, 0));
        send_leg(fill_leg(16'sh7FFF, 16'sh7FFF, 0));
        send_leg(fill_leg(-16'sh8000, -16'sh8000, 0));
        send_leg(fill_leg(16'sh7FFF, -16'sh8000, 1));
        send_leg(fill_leg(-16'sh8000, 16'sh7FFF, 1));
        send_leg(fill_leg(16'sd4096, 16'sd4096, 1));
        send_leg(fill_leg(16'sd1, 16'sh7FFF, 1));
        send_leg(fill_leg(-16'sd1, -16'sh8000, 1));
        for (int n = 0; n < 160; n++) send_leg(make_leg($urandom_range(0, 3)));

        for (int ph = 0; ph < 6; ph++) begin
            write_damping(damp_plan[ph]);
            if (ph == 0) begin
                // zero damping: singular cases and overflow of the rates
                send_leg(fill_leg(16'sd0, 16'sh7FFF, 0));
                send_leg(fill_leg(16'sh7FFF, 16'sd1, 0));
                send_leg(fill_leg(16'sd1, 16'sh7FFF, 1));
                send_leg(fill_leg(-16'sd1, -16'sh8000, 1));
                send_leg(fill_leg(16'sd4096, -16'sd4096, 1));
                send_leg(make_leg(2));
                send_leg(make_leg(3));
            end
            for (int n = 0; n < 145; n++) begin
                p = $urandom_range(0, 9);
                send_leg(make_leg(p < 4 ? 0 : p < 7 ? 1 : p < 9 ? 2 : 3));
            end
        end

        s_valid = 1'b0;
        while (sb.rates_due.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        $display("run covered %0d input beats over 7 damping settings, %0d results checked",
                 sent, sb.checked);
        $display("singular results %0d, saturated results %0d, errors %0d",
                 sb.n_singular, sb.n_saturated, sb.errors);
        if (sb.errors == 0 && sb.rates_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/dls_pkg.sv
rtl/dls_mul.sv
rtl/dls_div.sv
rtl/damped_least_squares_3x3_solve.sv
sim/tb_top.sv
